[design/assert_macros.svh]
// Assertion macros used by the checker module of the pair momentum block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define PRK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define PRK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/prk_pkg.sv]
// Constants and types of the pair relative momentum block
package prk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GUARD     = 8;
  localparam int P_W       = 20;
  localparam int M_W       = 18;
  localparam int KSTAR_W   = 17;
  localparam int PMASS_W   = 21;

  localparam int SQ_P_W    = 2 * P_W - 1;        // square of one momentum component
  localparam int SQ_S_W    = 2 * P_W + 1;        // square of a summed component
  localparam int SQ_M_W    = 2 * M_W;
  localparam int E2_W      = SQ_P_W + 1;         // three component squares plus mass square
  localparam int PSUM_W    = SQ_S_W + 1;
  localparam int RAD_W     = 58;                 // radicand width of every square root
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int QUO_W     = ROOT_W - 1;
  localparam int DIV_LAT   = QUO_W;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int MP_W      = M_W + 1 + GUARD;
  localparam int MP2_W     = 2 * MP_W;
  localparam int MEV_W     = 14;
  localparam int KMUL_W    = QUO_W + MEV_W + 1;

  localparam logic [MEV_W-1:0]   MEV16_PER_GEV = MEV_W'(16000);
  localparam logic [KSTAR_W-1:0] KSTAR_MAX     = '1;
  localparam logic [PMASS_W-1:0] PMASS_MAX     = '1;

  localparam longint FIXED_MASS_RAW = (longint'(15) << FRAC_BITS) >> 3;
  localparam longint MASS_MAX       = (longint'(1) << M_W) - 1;
  localparam logic [M_W-1:0] FIXED_MASS_RESET =
    M_W'((FIXED_MASS_RAW > MASS_MAX) ? MASS_MAX : FIXED_MASS_RAW);

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_FIXED  = 2'd0,
    REG_FIXED_MASS = 2'd1
  } cfg_reg_t;

  function automatic logic [SQ_P_W-1:0] sq_p(input logic signed [P_W-1:0] x);
    logic signed [2*P_W-1:0] w;
    w = (2*P_W)'(x);
    return SQ_P_W'(w * w);
  endfunction

  function automatic logic [SQ_S_W-1:0] sq_s(input logic signed [P_W:0] x);
    logic signed [2*P_W+1:0] w;
    w = (2*P_W+2)'(x);
    return SQ_S_W'(w * w);
  endfunction

endpackage

[design/prk_pair_if.sv]
// Input channel: one particle pair per beat
interface prk_pair_if;
  logic                              valid;
  logic                              ready;
  logic signed [prk_pkg::P_W-1:0]    first_px;
  logic signed [prk_pkg::P_W-1:0]    first_py;
  logic signed [prk_pkg::P_W-1:0]    first_pz;
  logic        [prk_pkg::M_W-1:0]    first_mass;
  logic signed [prk_pkg::P_W-1:0]    second_px;
  logic signed [prk_pkg::P_W-1:0]    second_py;
  logic signed [prk_pkg::P_W-1:0]    second_pz;
  logic        [prk_pkg::M_W-1:0]    second_mass;

  modport source (output valid, first_px, first_py, first_pz, first_mass,
                  second_px, second_py, second_pz, second_mass, input ready);
  modport sink (input valid, first_px, first_py, first_pz, first_mass,
                second_px, second_py, second_pz, second_mass, output ready);
endinterface

[design/prk_result_if.sv]
// Output channel: k*, pair mass and degenerate flag per beat
interface prk_result_if;
  logic                          valid;
  logic                          ready;
  logic [prk_pkg::KSTAR_W-1:0]   kstar;
  logic [prk_pkg::PMASS_W-1:0]   pair_mass;
  logic                          degenerate;

  modport source (output valid, kstar, pair_mass, degenerate, input ready);
  modport sink (input valid, kstar, pair_mass, degenerate, output ready);
endinterface

[design/prk_cfg_if.sv]
// Configuration write channel
interface prk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prk_pkg::CFG_IDX_W-1:0]   index;
  logic [prk_pkg::M_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/prk_sqrt.sv]
// Pipelined integer square root, one root bit per stage
module prk_sqrt (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [prk_pkg::RAD_W-1:0]     rad,
  output logic [prk_pkg::ROOT_W-1:0]    root
);

  localparam int RW = prk_pkg::RAD_W;
  localparam int QW = prk_pkg::ROOT_W;

  logic [RW-1:0] rem_r  [QW-1];
  logic [QW-1:0] root_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] root_in;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // test (2q + 2^BIT) * 2^BIT against what is left of the radicand
    assign trial = (RW'(root_in) << (BIT + 1)) | (RW'(1) << (2 * BIT));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= take ? (root_in | (QW'(1) << BIT)) : root_in;
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[QW-1];

endmodule

[design/prk_div.sv]
// Pipelined restoring divider, one quotient bit per stage
module prk_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [prk_pkg::RAD_W-1:0]     num,
  input  logic [prk_pkg::DEN_W-1:0]     den,
  output logic [prk_pkg::QUO_W-1:0]     quo
);

  localparam int RW = prk_pkg::RAD_W;
  localparam int QW = prk_pkg::QUO_W;
  localparam int DW = prk_pkg::DEN_W;

  logic [RW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = RW'(den_in) << BIT;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[k] <= take ? (quo_in | (QW'(1) << BIT)) : quo_in;
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= take ? (rem_in - trial) : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

[design/pair_relative_momentum_kstar.sv]
// Top level: k* and invariant mass of a particle pair, fully pipelined
// Throughput: one pair per cycle unless the skid stage is full; depth is set by two
// successive 29-stage square root pipelines and a 28-stage divider, one bit per stage.
// Reset: synchronous, clears all valid bits, output and skid stage; configuration
// returns to fixed second mass 1.875 GeV.
module pair_relative_momentum_kstar (
  input  logic        clk,
  input  logic        rst,
  prk_pair_if.sink    pair,
  prk_result_if.source result,
  prk_cfg_if.sink     cfg
);

  localparam int P_W    = prk_pkg::P_W;
  localparam int M_W    = prk_pkg::M_W;
  localparam int RAD_W  = prk_pkg::RAD_W;
  localparam int ROOT_W = prk_pkg::ROOT_W;
  localparam int GUARD  = prk_pkg::GUARD;
  localparam int SQL    = prk_pkg::SQRT_LAT;
  localparam int DVL    = prk_pkg::DIV_LAT;
  localparam int KSH    = prk_pkg::FRAC_BITS + GUARD;
  localparam int KW     = prk_pkg::KMUL_W;
  localparam int MSUM_W = ROOT_W + 1;

  typedef struct packed {
    logic [RAD_W-1:0]          psq;
    logic [prk_pkg::MP_W-1:0]  mp;
    logic [prk_pkg::MP_W-1:0]  mm;
  } side_e_t;

  typedef struct packed {
    logic                          degen;
    logic [prk_pkg::PMASS_W-1:0]   mout;
  } side_g_t;

  typedef struct packed {
    logic [prk_pkg::KSTAR_W-1:0]   kstar;
    logic [prk_pkg::PMASS_W-1:0]   pair_mass;
    logic                          degenerate;
  } res_t;

  // configuration
  logic           use_fixed;
  logic [M_W-1:0] fixed_mass;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_fixed  <= 1'b1;
      fixed_mass <= prk_pkg::FIXED_MASS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        prk_pkg::REG_USE_FIXED:  use_fixed  <= cfg.data[0];
        prk_pkg::REG_FIXED_MASS: fixed_mass <= cfg.data;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline moves unless the skid stage is full
  logic adv;
  logic skid_valid;
  assign adv        = !skid_valid;
  assign pair.ready = adv;

  // stage 1: capture
  logic                  v1;
  logic signed [P_W-1:0] ax, ay, az, bx, by, bz;
  logic [M_W-1:0]        m1, m2;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= pair.valid;
    if (adv) begin
      ax <= pair.first_px;
      ay <= pair.first_py;
      az <= pair.first_pz;
      m1 <= pair.first_mass;
      bx <= pair.second_px;
      by <= pair.second_py;
      bz <= pair.second_pz;
      m2 <= use_fixed ? fixed_mass : pair.second_mass;
    end
  end

  // stage 2: component squares and pair momentum
  logic                          v2;
  logic [prk_pkg::SQ_P_W-1:0]    sqax, sqay, sqaz, sqbx, sqby, sqbz;
  logic [prk_pkg::SQ_M_W-1:0]    sqm1, sqm2;
  logic signed [P_W:0]           sx, sy, sz;
  logic [M_W-1:0]                m1_2, m2_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      sqax <= prk_pkg::sq_p(ax);
      sqay <= prk_pkg::sq_p(ay);
      sqaz <= prk_pkg::sq_p(az);
      sqbx <= prk_pkg::sq_p(bx);
      sqby <= prk_pkg::sq_p(by);
      sqbz <= prk_pkg::sq_p(bz);
      sqm1 <= prk_pkg::SQ_M_W'(m1) * prk_pkg::SQ_M_W'(m1);
      sqm2 <= prk_pkg::SQ_M_W'(m2) * prk_pkg::SQ_M_W'(m2);
      sx   <= (P_W+1)'(ax) + (P_W+1)'(bx);
      sy   <= (P_W+1)'(ay) + (P_W+1)'(by);
      sz   <= (P_W+1)'(az) + (P_W+1)'(bz);
      m1_2 <= m1;
      m2_2 <= m2;
    end
  end

  // stage 3: squared energies and squared pair momentum terms
  logic                          v3;
  logic [prk_pkg::E2_W-1:0]      e2a, e2b;
  logic [prk_pkg::SQ_S_W-1:0]    sqsx, sqsy, sqsz;
  logic [M_W-1:0]                m1_3, m2_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      e2a  <= prk_pkg::E2_W'(sqax) + prk_pkg::E2_W'(sqay) + prk_pkg::E2_W'(sqaz)
              + prk_pkg::E2_W'(sqm1);
      e2b  <= prk_pkg::E2_W'(sqbx) + prk_pkg::E2_W'(sqby) + prk_pkg::E2_W'(sqbz)
              + prk_pkg::E2_W'(sqm2);
      sqsx <= prk_pkg::sq_s(sx);
      sqsy <= prk_pkg::sq_s(sy);
      sqsz <= prk_pkg::sq_s(sz);
      m1_3 <= m1_2;
      m2_3 <= m2_2;
    end
  end

  // energy square roots, sideband travels alongside
  logic [ROOT_W-1:0] ea, eb;
  logic [RAD_W-1:0]  rad_ea, rad_eb;
  assign rad_ea = RAD_W'(e2a) << (2 * GUARD);
  assign rad_eb = RAD_W'(e2b) << (2 * GUARD);

  prk_sqrt u_sqrt_ea (.clk(clk), .adv(adv), .rad(rad_ea), .root(ea));
  prk_sqrt u_sqrt_eb (.clk(clk), .adv(adv), .rad(rad_eb), .root(eb));

  side_e_t             side_e_in;
  side_e_t             side_e [SQL];
  logic [SQL-1:0]      side_e_v;
  logic [M_W:0]        msum, mdiff;

  assign msum  = (M_W+1)'(m1_3) + (M_W+1)'(m2_3);
  assign mdiff = (m1_3 > m2_3) ? (M_W+1)'(m1_3 - m2_3) : (M_W+1)'(m2_3 - m1_3);
  assign side_e_in.psq = RAD_W'(prk_pkg::PSUM_W'(sqsx) + prk_pkg::PSUM_W'(sqsy)
                                + prk_pkg::PSUM_W'(sqsz)) << (2 * GUARD);
  assign side_e_in.mp  = prk_pkg::MP_W'(msum) << GUARD;
  assign side_e_in.mm  = prk_pkg::MP_W'(mdiff) << GUARD;

  always_ff @(posedge clk) begin
    if (rst) side_e_v <= '0;
    else if (adv) side_e_v <= {side_e_v[SQL-2:0], v3};
    if (adv) begin
      side_e[0] <= side_e_in;
      for (int k = 1; k < SQL; k++) side_e[k] <= side_e[k-1];
    end
  end

  // stage 5: energy sum, mass terms squared
  logic                         v5;
  logic [ROOT_W-1:0]            esum;
  logic [RAD_W-1:0]             psq5;
  logic [prk_pkg::MP2_W-1:0]    mp2, mm2;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= side_e_v[SQL-1];
    if (adv) begin
      esum <= ea + eb;
      psq5 <= side_e[SQL-1].psq;
      mp2  <= prk_pkg::MP2_W'(side_e[SQL-1].mp) * prk_pkg::MP2_W'(side_e[SQL-1].mp);
      mm2  <= prk_pkg::MP2_W'(side_e[SQL-1].mm) * prk_pkg::MP2_W'(side_e[SQL-1].mm);
    end
  end

  // stage 6: squared energy sum
  logic                         v6;
  logic [RAD_W-1:0]             esq, psq6;
  logic [prk_pkg::MP2_W-1:0]    mp2_6, mm2_6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
    if (adv) begin
      esq   <= RAD_W'(esum) * RAD_W'(esum);
      psq6  <= psq5;
      mp2_6 <= mp2;
      mm2_6 <= mm2;
    end
  end

  // stage 7: invariant mass squared
  logic                         v7;
  logic [RAD_W-1:0]             s7;
  logic                         degen7;
  logic [prk_pkg::MP2_W-1:0]    mp2_7, mm2_7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
    if (adv) begin
      s7     <= esq - psq6;
      degen7 <= (esq <= psq6);
      mp2_7  <= mp2_6;
      mm2_7  <= mm2_6;
    end
  end

  // three square roots; clamp radicands below threshold to zero
  logic [RAD_W-1:0]  rad_a, rad_b;
  logic [ROOT_W-1:0] ra, rb, rs;

  assign rad_a = (s7 > RAD_W'(mp2_7)) ? (s7 - RAD_W'(mp2_7)) : '0;
  assign rad_b = (s7 > RAD_W'(mm2_7)) ? (s7 - RAD_W'(mm2_7)) : '0;

  prk_sqrt u_sqrt_ra (.clk(clk), .adv(adv), .rad(rad_a), .root(ra));
  prk_sqrt u_sqrt_rb (.clk(clk), .adv(adv), .rad(rad_b), .root(rb));
  prk_sqrt u_sqrt_rs (.clk(clk), .adv(adv), .rad(s7),    .root(rs));

  logic [SQL-1:0] side_f_v;
  logic [SQL-1:0] side_f_degen;

  always_ff @(posedge clk) begin
    if (rst) side_f_v <= '0;
    else if (adv) side_f_v <= {side_f_v[SQL-2:0], v7};
    if (adv) side_f_degen <= {side_f_degen[SQL-2:0], degen7};
  end

  // stage 8: product of roots, divisor, rounded pair mass
  logic                          v8;
  logic [RAD_W-1:0]              prod;
  logic [prk_pkg::DEN_W-1:0]     den;
  side_g_t                       g8;
  logic [MSUM_W-1:0]             msum_r;
  logic [MSUM_W-GUARD-1:0]       mshift;
  logic [prk_pkg::PMASS_W-1:0]   mout;
  logic                          degen_f;

  assign degen_f = side_f_degen[SQL-1];
  assign msum_r  = MSUM_W'(rs) + (MSUM_W'(1) << (GUARD - 1));
  assign mshift  = msum_r[MSUM_W-1:GUARD];
  assign mout    = degen_f ? '0 :
                   (mshift > (MSUM_W-GUARD)'(prk_pkg::PMASS_MAX)) ? prk_pkg::PMASS_MAX :
                   prk_pkg::PMASS_W'(mshift);

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= side_f_v[SQL-1];
    if (adv) begin
      prod     <= RAD_W'(ra) * RAD_W'(rb);
      // a degenerate pair has no root of s; divide by one and drop the quotient later
      den      <= degen_f ? prk_pkg::DEN_W'(1) : {rs, 1'b0};
      g8.degen <= degen_f;
      g8.mout  <= mout;
    end
  end

  // divider and its sideband
  logic [prk_pkg::QUO_W-1:0] kraw;
  side_g_t                   side_g [DVL];
  logic [DVL-1:0]            side_g_v;

  prk_div u_div (.clk(clk), .adv(adv), .num(prod), .den(den), .quo(kraw));

  always_ff @(posedge clk) begin
    if (rst) side_g_v <= '0;
    else if (adv) side_g_v <= {side_g_v[DVL-2:0], v8};
    if (adv) begin
      side_g[0] <= g8;
      for (int k = 1; k < DVL; k++) side_g[k] <= side_g[k-1];
    end
  end

  // stage 9: scale to 1/16 MeV
  logic          v9;
  logic [KW-1:0] kmul;
  side_g_t       g9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (adv) v9 <= side_g_v[DVL-1];
    if (adv) begin
      kmul <= KW'(kraw) * KW'(prk_pkg::MEV16_PER_GEV);
      g9   <= side_g[DVL-1];
    end
  end

  // final rounding and saturation
  logic [KW-1:0]     ksum;
  logic [KW-KSH-1:0] kshift;
  res_t              res_new;

  assign ksum   = kmul + (KW'(1) << (KSH - 1));
  assign kshift = ksum[KW-1:KSH];
  assign res_new.kstar      = g9.degen ? '0 :
                              (kshift > (KW-KSH)'(prk_pkg::KSTAR_MAX)) ? prk_pkg::KSTAR_MAX :
                              prk_pkg::KSTAR_W'(kshift);
  assign res_new.pair_mass  = g9.mout;
  assign res_new.degenerate = g9.degen;

  // output register with one skid entry
  logic out_valid;
  res_t out_r, skid_r;
  logic push;

  assign push = adv && v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result.ready) begin
      // output held: park a new beat in the skid entry
      if (push) begin
        skid_valid <= 1'b1;
        skid_r     <= res_new;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_r      <= skid_r;
      skid_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_r     <= res_new;
    end else begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid      = out_valid;
  assign result.kstar      = out_r.kstar;
  assign result.pair_mass  = out_r.pair_mass;
  assign result.degenerate = out_r.degenerate;

endmodule

[design/prk_checker.sv]
// Port-level checks of the pair momentum block and their binding
`include "assert_macros.svh"

module prk_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [prk_pkg::KSTAR_W-1:0]   kstar,
  input  logic [prk_pkg::PMASS_W-1:0]   pair_mass,
  input  logic                          degenerate
);

  `PRK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
  `PRK_ASSERT(a_degen_zero, out_valid && degenerate |-> kstar == 0 && pair_mass == 0, "degenerate beat with nonzero fields")
  `PRK_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with empty output")
  `PRK_ASSERT_ALWAYS(a_reset_empty, rst |=> in_ready && !out_valid, "pipeline not empty after reset")

endmodule

bind pair_relative_momentum_kstar prk_checker u_prk_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pair.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .kstar      (result.kstar),
  .pair_mass  (result.pair_mass),
  .degenerate (result.degenerate)
);

[test/prk_kstar_checker.sv]
// Checker for the pair relative momentum block: predicts k* and pair mass, compares beats
module prk_kstar_checker (
  input  logic      clk,
  input  logic      rst,
  prk_pair_if       pair,
  prk_result_if     result,
  prk_cfg_if        cfg,
  output int        fail_count,
  output int        pending,
  output int        n_checked,
  output int        n_degenerate,
  output int        n_kstar_sat,
  output int        n_kstar_zero
);

  typedef struct packed {
    logic [prk_pkg::KSTAR_W-1:0] kstar;
    logic [prk_pkg::PMASS_W-1:0] pair_mass;
    logic                        degenerate;
  } kinematics_t;

  kinematics_t               kinematics_q[$];
  logic                      use_fixed;
  logic [prk_pkg::M_W-1:0]   fixed_mass;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned square_of(input longint x);
    longint unsigned a;
    a = (x < 0) ? -x : x;
    return a * a;
  endfunction

  function automatic longint unsigned energy_of(input longint x, input longint y,
                                                input longint z, input longint unsigned m);
    return root_floor((square_of(x) + square_of(y) + square_of(z) + m * m)
                      << (2 * prk_pkg::GUARD));
  endfunction

  function automatic kinematics_t pair_kinematics(
      input longint ax, input longint ay, input longint az, input longint unsigned m1,
      input longint bx, input longint by, input longint bz, input longint unsigned m2);
    kinematics_t     k;
    longint unsigned esum, esq, psq, s, mp, mm, mp2, mm2, ra, rb, rs, kraw, kout, mout;
    esum = energy_of(ax, ay, az, m1) + energy_of(bx, by, bz, m2);
    esq  = esum * esum;
    psq  = (square_of(ax + bx) + square_of(ay + by) + square_of(az + bz))
           << (2 * prk_pkg::GUARD);
    k = '0;
    if (esq <= psq) begin
      k.degenerate = 1'b1;
      return k;
    end
    s   = esq - psq;
    mp  = (m1 + m2) << prk_pkg::GUARD;
    mm  = ((m1 > m2) ? m1 - m2 : m2 - m1) << prk_pkg::GUARD;
    mp2 = mp * mp;
    mm2 = mm * mm;
    ra  = root_floor((s > mp2) ? s - mp2 : 0);
    rb  = root_floor((s > mm2) ? s - mm2 : 0);
    rs  = root_floor(s);
    kraw = (ra * rb) / (2 * rs);
    kout = (kraw * 16000 + (64'd1 << (prk_pkg::FRAC_BITS + prk_pkg::GUARD - 1)))
           >> (prk_pkg::FRAC_BITS + prk_pkg::GUARD);
    if (kout > prk_pkg::KSTAR_MAX) kout = prk_pkg::KSTAR_MAX;
    mout = (rs + (64'd1 << (prk_pkg::GUARD - 1))) >> prk_pkg::GUARD;
    if (mout > prk_pkg::PMASS_MAX) mout = prk_pkg::PMASS_MAX;
    k.kstar     = kout[prk_pkg::KSTAR_W-1:0];
    k.pair_mass = mout[prk_pkg::PMASS_W-1:0];
    return k;
  endfunction

  always @(posedge clk) begin
    kinematics_t exp_k;
    longint unsigned m2;
    if (rst) begin
      use_fixed    <= 1'b1;
      fixed_mass   <= prk_pkg::FIXED_MASS_RESET;
      kinematics_q.delete();
      pending      <= 0;
      fail_count   <= 0;
      n_checked    <= 0;
      n_degenerate <= 0;
      n_kstar_sat  <= 0;
      n_kstar_zero <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          prk_pkg::REG_USE_FIXED:  use_fixed  <= cfg.data[0];
          prk_pkg::REG_FIXED_MASS: fixed_mass <= cfg.data;
          default: ;
        endcase
      end
      if (pair.valid && pair.ready) begin
        m2 = 64'(use_fixed ? fixed_mass : pair.second_mass);
        kinematics_q.push_back(pair_kinematics(
          longint'(pair.first_px), longint'(pair.first_py), longint'(pair.first_pz),
          longint'(pair.first_mass),
          longint'(pair.second_px), longint'(pair.second_py), longint'(pair.second_pz), m2));
      end
      if (result.valid && result.ready) begin
        if (kinematics_q.size() == 0) begin
          $error("unexpected result beat: kstar %0d pair_mass %0d",
                 result.kstar, result.pair_mass);
          fail_count <= fail_count + 1;
        end else begin
          exp_k = kinematics_q.pop_front();
          n_checked    <= n_checked + 1;
          n_degenerate <= n_degenerate + exp_k.degenerate;
          n_kstar_sat  <= n_kstar_sat + (exp_k.kstar == prk_pkg::KSTAR_MAX);
          n_kstar_zero <= n_kstar_zero + (exp_k.kstar == 0 && !exp_k.degenerate);
          if (result.kstar !== exp_k.kstar ||
              result.pair_mass !== exp_k.pair_mass ||
              result.degenerate !== exp_k.degenerate) begin
            if (result.kstar !== exp_k.kstar)
              $error("kstar: expected %0d, got %0d", exp_k.kstar, result.kstar);
            if (result.pair_mass !== exp_k.pair_mass)
              $error("pair_mass: expected %0d, got %0d", exp_k.pair_mass, result.pair_mass);
            if (result.degenerate !== exp_k.degenerate)
              $error("degenerate: expected %0d, got %0d", exp_k.degenerate, result.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= kinematics_q.size();
    end
  end

endmodule

[test/tb_pair_relative_momentum_kstar.sv]
// Testbench top: pair stimulus, config phases, backpressure and verdict
module tb_pair_relative_momentum_kstar;

  localparam int P_W = prk_pkg::P_W;
  localparam int M_W = prk_pkg::M_W;
  localparam logic [prk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_LAT     = 95;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic hold_now = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, n_checked, n_degenerate, n_kstar_sat, n_kstar_zero;

  prk_pair_if   pair();
  prk_result_if result();
  prk_cfg_if    cfg();

  pair_relative_momentum_kstar dut (
    .clk(clk), .rst(rst), .pair(pair), .result(result), .cfg(cfg)
  );

  prk_kstar_checker checker_i (
    .clk(clk), .rst(rst), .pair(pair), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .n_checked(n_checked),
    .n_degenerate(n_degenerate), .n_kstar_sat(n_kstar_sat), .n_kstar_zero(n_kstar_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        result.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_now = 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 5) == 0) begin
        result.ready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  task automatic send_pair(input int ax, ay, az, m1, bx, by, bz, m2);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pair.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pair.first_px  = P_W'(ax); pair.first_py  = P_W'(ay); pair.first_pz  = P_W'(az);
    pair.first_mass  = M_W'(m1);
    pair.second_px = P_W'(bx); pair.second_py = P_W'(by); pair.second_pz = P_W'(bz);
    pair.second_mass = M_W'(m2);
    pair.valid = 1'b1;
    do @(posedge clk); while (!pair.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    pair.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [prk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [M_W-1:0] value);
    drain();
    cfg.index = idx;
    cfg.data  = value;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_random();
    int ax, ay, az, bx, by, bz;
    int m1, m2;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      ax = $urandom; ay = $urandom; az = $urandom; m1 = $urandom;
      bx = $urandom; by = $urandom; bz = $urandom; m2 = $urandom;
    end else if (kind < 8) begin
      // physical pairs: momenta within 2 GeV, masses within 2 GeV
      ax = $urandom_range(0, 262143) - 131072;
      ay = $urandom_range(0, 262143) - 131072;
      az = $urandom_range(0, 262143) - 131072;
      bx = $urandom_range(0, 262143) - 131072;
      by = $urandom_range(0, 262143) - 131072;
      bz = $urandom_range(0, 262143) - 131072;
      m1 = $urandom_range(0, 131072);
      m2 = $urandom_range(0, 131072);
    end else begin
      // near threshold: second particle close to the first in momentum and mass
      ax = $urandom_range(0, 262143) - 131072;
      ay = $urandom_range(0, 262143) - 131072;
      az = $urandom_range(0, 262143) - 131072;
      m1 = $urandom_range(0, 131072);
      bx = ax + $urandom_range(0, 64) - 32;
      by = ay + $urandom_range(0, 64) - 32;
      bz = az + $urandom_range(0, 64) - 32;
      m2 = m1 + $urandom_range(0, 16);
    end
    send_pair(ax, ay, az, m1, bx, by, bz, m2);
  endtask

  task automatic send_directed();
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(1000, 0, 0, 0, 1000, 0, 0, 0);
    send_pair(-524288, 0, 0, 0, -524288, 0, 0, 0);
    send_pair(524287, 524287, 524287, 262143, 524287, 524287, 524287, 262143);
    send_pair(-524288, -524288, -524288, 262143, -524288, -524288, -524288, 262143);
    send_pair(524287, 524287, 524287, 0, -524288, -524288, -524288, 0);
    send_pair(524287, -524288, 524287, 262143, -524288, 524287, -524288, 0);
    send_pair(65536, 32768, -16384, 61489, 65536, 32768, -16384, 61489);
    send_pair(0, 0, 0, 0, 0, 0, 0, 262143);
    send_pair(0, 0, 0, 262143, 0, 0, 0, 0);
    send_pair(1, -1, 1, 1, -1, 1, -1, 1);
    send_pair(13107, 0, 0, 9150, -13107, 0, 0, 61489);
    send_pair(200000, 0, 0, 65536, -200000, 0, 0, 65536);
    send_pair(0, 524287, 0, 0, 0, 0, -524288, 0);
    send_pair(-1, -1, -1, 262143, 0, 0, 0, 131072);
  endtask

  initial begin
    logic            use_list[6];
    logic [M_W-1:0]  mass_list[6];
    use_list = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    pair.valid = 1'b0;
    pair.first_px = '0; pair.first_py = '0; pair.first_pz = '0; pair.first_mass = '0;
    pair.second_px = '0; pair.second_py = '0; pair.second_pz = '0; pair.second_mass = '0;
    cfg.valid = 1'b0;
    cfg.index = prk_pkg::REG_USE_FIXED;
    cfg.data  = '0;
    mass_list = '{prk_pkg::FIXED_MASS_RESET, 18'd0, 18'd262143, M_W'($urandom),
                  M_W'($urandom), prk_pkg::FIXED_MASS_RESET};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset configuration first, with a write to an unmapped index that must be ignored
    cfg_write(REG_UNUSED, '1);
    send_directed();
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(prk_pkg::REG_USE_FIXED, M_W'(use_list[ph]));
      cfg_write(prk_pkg::REG_FIXED_MASS, mass_list[ph]);
      if (ph == 1) send_directed();
      if (ph == 3) hold_now = 1'b1;
      if (ph == 5) calm = 1'b1;
      repeat (330) send_random();
    end
    drain();
    repeat (PIPE_LAT + 20) @(negedge clk);

    $display("checked %0d pair results under the reset setting and six written config phases:",
             n_checked);
    $display("%0d degenerate, %0d k* saturated, %0d k* at threshold",
             n_degenerate, n_kstar_sat, n_kstar_zero);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
